// ----- rtl/core/lfu_pkg.sv -----
// Package for the LFU cache with LRU tie-break.
// Holds the control/status structs, the controller state encoding and fixed widths.
// No dependencies.
package lfu_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 31;
  localparam int CFG_W   = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] CFG_CAP_RESET = 5'd16;

  // Value of the top address bit that selects the capacity register on the configuration port.
  localparam logic REG_ACTIVE_CAP = 1'b0;

  // Operation codes of the kind field.
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } lfu_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } lfu_cmd_t;

  typedef struct packed {
    logic scan_done;
  } lfu_stat_t;

endpackage

// ----- rtl/core/lfu_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lfu_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/lfu_ctrl.sv -----
// Controller state machine for the LFU cache: idle, entry scan, commit.
// Depends on lfu_pkg.
module lfu_ctrl import lfu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  lfu_stat_t stat,
  output lfu_cmd_t  cmd,
  output logic      busy
);

  lfu_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- rtl/core/lfu_dp.sv -----
// Datapath of the LFU cache: entry memories, valid bits, recency ranks,
// scan pipeline with key match and victim tracking, commit of one request.
// Depends on lfu_pkg and lfu_ram.
module lfu_dp import lfu_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lfu_cmd_t         cmd,
  output lfu_stat_t        stat,
  input  logic [CFG_W-1:0] active_capacity,
  input  logic             cfg_clear,
  input  logic             in_kind,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  output logic             out_hit,
  output logic [VAL_W-1:0] out_read_value,
  output logic             out_evicted
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Captured request
  logic             kind_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;

  // Scan pipeline
  logic [CW-1:0] addr_r;
  logic          pend_r;
  logic [IW-1:0] idx_r;

  // Scan results
  logic                  found_r;
  logic [IW-1:0]         fidx_r;
  logic [VAL_W-1:0]      fval_r;
  logic [COUNT_BITS-1:0] fcnt_r;
  logic [IW-1:0]         frank_r;
  logic                  vic_ok_r;
  logic [IW-1:0]         vidx_r;
  logic [COUNT_BITS-1:0] vcnt_r;
  logic [IW-1:0]         vrank_r;
  logic [CW-1:0]         occ_r;
  logic                  free_ok_r;
  logic [IW-1:0]         free_idx_r;

  // Per-entry state
  logic [CAPACITY-1:0] valid_r;
  logic [IW-1:0]       rank_r [CAPACITY];

  // Output registers
  logic             out_valid_r;
  logic             out_hit_r;
  logic [VAL_W-1:0] out_rd_r;
  logic             out_ev_r;

  // Memory ports
  logic [KEY_W-1:0]      key_rd;
  logic [VAL_W-1:0]      val_rd;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [IW-1:0]         wr_addr;
  logic                  key_we, val_we, cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata;

  logic [CW-1:0] cap;
  logic          cap_zero;
  logic          issue;
  logic          e_valid;
  logic [IW-1:0] e_rank;
  logic          hit, do_ins, full, do_evict, ins_ok;
  logic [IW-1:0] slot;

  always_comb begin
    if (32'(active_capacity) > 32'(CAPACITY)) begin
      cap = CW'(CAPACITY);
    end else begin
      cap = CW'(active_capacity);
    end
  end
  assign cap_zero = (cap == '0);

  assign issue      = cmd.scan && (32'(addr_r) < 32'(CAPACITY));
  assign e_valid    = valid_r[idx_r];
  assign e_rank     = rank_r[idx_r];
  assign stat.scan_done = pend_r && (32'(addr_r) == 32'(CAPACITY));

  lfu_ram #(.DATA_W(KEY_W), .DEPTH(CAPACITY), .ADDR_W(IW)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_r),
    .raddr (addr_r[IW-1:0]),
    .rdata (key_rd)
  );

  lfu_ram #(.DATA_W(VAL_W), .DEPTH(CAPACITY), .ADDR_W(IW)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (wr_addr),
    .wdata (value_r),
    .raddr (addr_r[IW-1:0]),
    .rdata (val_rd)
  );

  lfu_ram #(.DATA_W(COUNT_BITS), .DEPTH(CAPACITY), .ADDR_W(IW)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (wr_addr),
    .wdata (cnt_wdata),
    .raddr (addr_r[IW-1:0]),
    .rdata (cnt_rd)
  );

  // Commit decisions
  assign hit      = found_r && !cap_zero;
  assign do_ins   = !cap_zero && !found_r && (kind_r == KIND_PUT);
  assign full     = (occ_r >= cap);
  assign do_evict = do_ins && full && vic_ok_r;
  assign ins_ok   = do_ins && (free_ok_r || do_evict);

  always_comb begin
    if (do_evict && !(free_ok_r && (free_idx_r < vidx_r))) begin
      slot = vidx_r;
    end else begin
      slot = free_idx_r;
    end
  end

  assign wr_addr   = hit ? fidx_r : slot;
  assign key_we    = cmd.commit && ins_ok;
  assign val_we    = cmd.commit && ((hit && (kind_r == KIND_PUT)) || ins_ok);
  assign cnt_we    = cmd.commit && (hit || ins_ok);
  assign cnt_wdata = hit ? ((fcnt_r == COUNT_MAX) ? fcnt_r : fcnt_r + 1'b1)
                         : COUNT_BITS'(1);

  // Request capture and scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      key_r     <= in_key;
      value_r   <= in_value;
      addr_r    <= '0;
      found_r   <= 1'b0;
      vic_ok_r  <= 1'b0;
      occ_r     <= '0;
      free_ok_r <= 1'b0;
    end else begin
      if (issue) begin
        idx_r  <= addr_r[IW-1:0];
        addr_r <= addr_r + 1'b1;
      end
      if (pend_r) begin
        if (e_valid) begin
          occ_r <= occ_r + 1'b1;
          if (key_rd == key_r) begin
            found_r <= 1'b1;
            fidx_r  <= idx_r;
            fval_r  <= val_rd;
            fcnt_r  <= cnt_rd;
            frank_r <= e_rank;
          end
          if (!vic_ok_r || (cnt_rd < vcnt_r) ||
              ((cnt_rd == vcnt_r) && (e_rank > vrank_r))) begin
            vic_ok_r <= 1'b1;
            vidx_r   <= idx_r;
            vcnt_r   <= cnt_rd;
            vrank_r  <= e_rank;
          end
        end else if (!free_ok_r) begin
          free_ok_r  <= 1'b1;
          free_idx_r <= idx_r;
        end
      end
    end
  end

  // Valid bits and recency ranks, updated in parallel at commit; valid bits also clear on reset or a capacity write
  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    localparam logic [IW-1:0] ME = IW'(i);

    always_ff @(posedge clk) begin
      if (!rst_n || cfg_clear) begin
        valid_r[i] <= 1'b0;
      end else if (cmd.commit) begin
        if (ins_ok && (slot == ME)) begin
          valid_r[i] <= 1'b1;
        end else if (do_evict && (vidx_r == ME)) begin
          valid_r[i] <= 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.commit) begin
        if (hit) begin
          if (fidx_r == ME) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (rank_r[i] < frank_r)) begin
            rank_r[i] <= rank_r[i] + 1'b1;
          end
        end else if (ins_ok) begin
          if (slot == ME) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && !(do_evict && (rank_r[i] > vrank_r))) begin
            rank_r[i] <= rank_r[i] + 1'b1;
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r <= hit;
      out_rd_r  <= (hit && (kind_r == KIND_GET)) ? fval_r : '0;
      out_ev_r  <= do_ins && full;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_rd_r;
  assign out_evicted    = out_ev_r;

endmodule

// ----- rtl/core/lfu_cache_replacement.sv -----
// LFU cache with LRU tie-break: one request at a time, accepted only while the controller is
// idle; the result strobe is registered from the commit state. The entry scan reads one
// key/value/count memory row per cycle.
// The result strobe lasts one cycle and cannot be held off.
// Reset (rst_n low, synchronous): cache empty, active_capacity = 16, controller idle.
// Depends on lfu_pkg, lfu_ctrl, lfu_dp, lfu_ram.
module lfu_cache_replacement import lfu_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [VAL_W-1:0]   in_value,
  // result channel
  output logic               out_valid,
  output logic               out_hit,
  output logic [VAL_W-1:0]   out_read_value,
  output logic               out_evicted,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  lfu_cmd_t         cmd;
  lfu_stat_t        stat;
  logic [CFG_W-1:0] active_capacity_r;
  logic             cfg_wr;
  logic             cfg_clear;

  // Configuration: one register, zero wait states. Writing the capacity
  // also empties the cache so occupancy never exceeds the new capacity.
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cfg_clear = cfg_wr && (paddr[PADDR_W-1] == REG_ACTIVE_CAP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_capacity_r <= CFG_CAP_RESET;
    end else if (cfg_clear) begin
      active_capacity_r <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (paddr[PADDR_W-1] == REG_ACTIVE_CAP) begin
      prdata = {{(PDATA_W-CFG_W){1'b0}}, active_capacity_r};
    end else begin
      prdata = '0;
    end
  end

  // Controller: accept a request when idle, scan every entry slot, then commit.
  lfu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: hold the request, find the key and the eviction victim during
  // the scan, then update memories, valid bits and recency ranks at commit.
  lfu_dp #(
    .CAPACITY   (CAPACITY),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .active_capacity (active_capacity_r),
    .cfg_clear       (cfg_clear),
    .in_kind         (in_kind),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted)
  );

endmodule

// ----- rtl/core/lfu_checker.sv -----
// Port-level checker for the LFU cache, bound to the top level.
// Depends on lfu_pkg.
module lfu_checker import lfu_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic             out_hit,
  input logic [VAL_W-1:0] out_read_value,
  input logic             out_evicted
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_read_value == '0))
    else $error("read value nonzero on a miss");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit and eviction in one result");

endmodule

bind lfu_cache_replacement lfu_checker u_lfu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_hit        (out_hit),
  .out_read_value (out_read_value),
  .out_evicted    (out_evicted)
);

// ----- sim/tb.sv -----
// Self-checking testbench for lfu_cache_replacement, the LFU cache with LRU tie-break.
// Drives get/put requests and capacity writes, predicts every result in a shadow cache.
// Depends on lfu_pkg and the RTL under rtl/core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_pkg::*;

  // Built with a narrow use counter so that saturation is reached within a short run.
  localparam int CACHE_ENTRIES  = 16;
  localparam int USE_COUNT_BITS = 3;
  localparam int unsigned USE_COUNT_MAX = (1 << USE_COUNT_BITS) - 1;
  localparam int KEY_POOL      = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam int NUM_PHASES    = 8;
  localparam int NO_WRITE      = -1;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
  } outcome_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_kind = KIND_GET;
  logic [KEY_W-1:0]   in_key = '0;
  logic [VAL_W-1:0]   in_value = '0;
  logic               out_valid;
  logic               out_hit;
  logic [VAL_W-1:0]   out_read_value;
  logic               out_evicted;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lfu_cache_replacement #(
    .CAPACITY  (CACHE_ENTRIES),
    .COUNT_BITS(USE_COUNT_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_read_value(out_read_value),
    .out_evicted   (out_evicted),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Requests waiting for the driver, and outcomes waiting for the block to report them.
  request_t pending_requests[$];
  outcome_t expected_outcomes[$];

  // Shadow copy of the cache contents and the capacity register.
  logic             sh_valid [CACHE_ENTRIES];
  logic [KEY_W-1:0] sh_key   [CACHE_ENTRIES];
  logic [VAL_W-1:0] sh_value [CACHE_ENTRIES];
  int unsigned      sh_count [CACHE_ENTRIES];
  int               sh_rank  [CACHE_ENTRIES];
  int unsigned      sh_cap;

  logic [KEY_W-1:0] key_pool [KEY_POOL];
  int unsigned sender_idle_pct = 0;

  int error_count     = 0;
  int accepted_count  = 0;
  int checked_count   = 0;
  int hit_total       = 0;
  int evict_total     = 0;
  int saturated_uses  = 0;
  int settings_tried  = 0;
  int idle_cycles     = 0;

  // Phase plan: capacity written before the phase (none for the first), item count and
  // sender idle percentage. Capacity 0, 31 and 17 cover disabled and clamped settings.
  int phase_cap  [NUM_PHASES] = '{NO_WRITE, 0, 1, 2, 5, 31, 17, 16};
  int phase_items[NUM_PHASES] = '{130, 40, 90, 90, 110, 110, 80, 120};
  int phase_idle [NUM_PHASES] = '{0, 47, 6, 0, 47, 6, 0, 47};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow cache
  // ---------------------------------------------------------------------------

  function automatic void clear_shadow();
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      sh_valid[i] = 1'b0;
      sh_key[i]   = '0;
      sh_value[i] = '0;
      sh_count[i] = 0;
      sh_rank[i]  = 0;
    end
  endfunction

  // Make entry e the most recent one and count a use, holding the count at its ceiling.
  function automatic void mark_used(int e);
    for (int i = 0; i < CACHE_ENTRIES; i++)
      if (sh_valid[i] && i != e && sh_rank[i] < sh_rank[e])
        sh_rank[i]++;
    sh_rank[e] = 0;
    if (sh_count[e] < USE_COUNT_MAX)
      sh_count[e]++;
    else
      saturated_uses++;
  endfunction

  // Drop the least used entry; among equal counts the one used longest ago.
  function automatic void evict_least_used();
    int victim;
    victim = -1;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (!sh_valid[i])
        continue;
      if (victim < 0 || sh_count[i] < sh_count[victim] ||
          (sh_count[i] == sh_count[victim] && sh_rank[i] > sh_rank[victim]))
        victim = i;
    end
    if (victim < 0)
      return;
    for (int i = 0; i < CACHE_ENTRIES; i++)
      if (sh_valid[i] && sh_rank[i] > sh_rank[victim])
        sh_rank[i]--;
    sh_valid[victim] = 1'b0;
  endfunction

  // Apply one get or put to the shadow cache and return what the block must report.
  function automatic outcome_t cache_access_outcome(request_t r);
    outcome_t    o;
    int          found;
    int          free_slot;
    int unsigned occupied;
    int unsigned cap;
    o         = '0;
    found     = -1;
    free_slot = -1;
    occupied  = 0;
    cap = (sh_cap > CACHE_ENTRIES) ? CACHE_ENTRIES : sh_cap;
    if (cap != 0) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        if (sh_valid[i]) begin
          occupied++;
          if (sh_key[i] == r.key)
            found = i;
        end
      end
      if (found >= 0) begin
        o.hit = 1'b1;
        if (r.kind == KIND_PUT)
          sh_value[found] = r.value;
        else
          o.read_value = sh_value[found];
        mark_used(found);
      end else if (r.kind == KIND_PUT) begin
        if (occupied >= cap) begin
          evict_least_used();
          o.evicted = 1'b1;
        end
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (!sh_valid[i]) begin
            free_slot = i;
            break;
          end
        end
        if (free_slot >= 0) begin
          for (int i = 0; i < CACHE_ENTRIES; i++)
            if (sh_valid[i])
              sh_rank[i]++;
          sh_valid[free_slot] = 1'b1;
          sh_key[free_slot]   = r.key;
          sh_value[free_slot] = r.value;
          sh_count[free_slot] = 1;
          sh_rank[free_slot]  = 0;
        end
      end
    end
    if (o.hit)
      hit_total++;
    if (o.evicted)
      evict_total++;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_request(logic kind, logic [KEY_W-1:0] key,
                                        logic [VAL_W-1:0] value);
    request_t r;
    r.kind  = kind;
    r.key   = key;
    r.value = value;
    pending_requests.push_back(r);
  endfunction

  // Mostly keys from a small pool, a few of them hot so counts climb and saturate;
  // the rest are fresh random keys and the all-zero and all-one keys.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    r.kind = $urandom_range(1) ? KIND_PUT : KIND_GET;
    pick = $urandom_range(99);
    if (pick < 35)
      r.key = key_pool[$urandom_range(3)];
    else if (pick < 80)
      r.key = key_pool[$urandom_range(KEY_POOL - 1)];
    else if (pick < 92)
      r.key = $urandom;
    else
      r.key = pick[0] ? '1 : '0;
    pick = $urandom_range(99);
    if (pick < 80)
      r.value = VAL_W'($urandom);
    else if (pick < 90)
      r.value = '0;
    else
      r.value = '1;
    return r;
  endfunction

  // Hold until every queued request has gone in and every outcome has come back.
  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_outcomes.size() != 0 || start || busy)
      @(posedge clk);
  endtask

  task automatic read_capacity(input logic [CFG_W-1:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_ACTIVE_CAP, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(want)) begin
      $error("active_capacity readback mismatch: expected %0d, got %0d", want, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the capacity register; the block empties the cache on every write to this register.
  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ACTIVE_CAP, 2'b00};
    pwdata  <= PDATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sh_cap = cap;
    clear_shadow();
    settings_tried++;
    read_capacity(cap);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the oldest pending request, hold it until accepted
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    outcome_t o;
    logic     launch;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        o = cache_access_outcome(pending_requests[0]);
        expected_outcomes.push_back(o);
        void'(pending_requests.pop_front());
        accepted_count++;
      end
      launch = (pending_requests.size() != 0) && ($urandom_range(99) >= sender_idle_pct);
      if (launch) begin
        start    <= 1'b1;
        in_kind  <= pending_requests[0].kind;
        in_key   <= pending_requests[0].key;
        in_value <= pending_requests[0].value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result strobe with the oldest expected outcome
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid) begin
      if (expected_outcomes.size() == 0) begin
        $error("result strobe with no request outstanding");
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        checked_count++;
        if (out_hit !== want.hit) begin
          $error("hit mismatch: expected %0d, got %0d", want.hit, out_hit);
          error_count++;
        end
        if (out_read_value !== want.read_value) begin
          $error("read_value mismatch: expected 0x%0h, got 0x%0h",
                 want.read_value, out_read_value);
          error_count++;
        end
        if (out_evicted !== want.evicted) begin
          $error("evicted mismatch: expected %0d, got %0d", want.evicted, out_evicted);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: no progress for %0d cycles", STALL_LIMIT);
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  initial begin
    sh_cap = CFG_CAP_RESET;
    clear_shadow();
    for (int i = 0; i < KEY_POOL; i++)
      key_pool[i] = $urandom;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_capacity(CFG_CAP_RESET);

    // Directed: empty-cache miss, extreme keys and values, update of a present key,
    // a key used past the count ceiling, and a plain miss.
    queue_request(KIND_GET, 32'h0000_0000, '0);
    queue_request(KIND_PUT, 32'h0000_0000, 31'h7FFF_FFFF);
    queue_request(KIND_GET, 32'h0000_0000, 31'h1234_5678);
    queue_request(KIND_PUT, 32'hFFFF_FFFF, 31'h0000_0000);
    queue_request(KIND_GET, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    queue_request(KIND_PUT, 32'h0000_0000, 31'h0000_1234);
    queue_request(KIND_GET, 32'h0000_0000, '0);
    repeat (5) queue_request(KIND_GET, 32'h0000_0000, '0);
    queue_request(KIND_GET, 32'h1234_5678, '0);
    queue_request(KIND_PUT, 32'h8000_0000, 31'h2AAA_AAAA);
    queue_request(KIND_GET, 32'h8000_0000, '0);
    queue_request(KIND_PUT, 32'h5555_5555, 31'h5555_5555);
    wait_drained();

    // Random phases; each one pauses halfway until all results are back.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (phase_cap[p] != NO_WRITE)
        write_capacity(CFG_W'(phase_cap[p]));
      sender_idle_pct = phase_idle[p];
      for (int half = 0; half < 2; half++) begin
        for (int n = 0; n < phase_items[p] / 2; n++)
          pending_requests.push_back(random_request());
        wait_drained();
      end
    end

    // Let any stray strobe show up before the verdict.
    repeat (CACHE_ENTRIES + 8) @(posedge clk);
    if (expected_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", expected_outcomes.size());
      error_count++;
    end

    $display("tb: %0d requests, %0d results checked, %0d capacity writes (0 to 31)",
             accepted_count, checked_count, settings_tried);
    $display("tb: %0d hits, %0d evictions, %0d uses at the count ceiling",
             hit_total, evict_total, saturated_uses);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lfu_pkg.sv
rtl/core/lfu_ram.sv
rtl/core/lfu_ctrl.sv
rtl/core/lfu_dp.sv
rtl/core/lfu_cache_replacement.sv
rtl/core/lfu_checker.sv
sim/tb.sv
